// ===== hw/rtl/monotonic_clock_sample_filter_core_defines.svh =====
// assertion macros for the monotonic clock sample filter
// used by files that assert; expects clk and rst_n in scope
`ifndef MONOTONIC_CLOCK_SAMPLE_FILTER_CORE_DEFINES_SVH
`define MONOTONIC_CLOCK_SAMPLE_FILTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCSF_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MCSF_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mcsf_pkg.sv =====
// shared types and constants for the monotonic clock sample filter
// no dependencies
`default_nettype none

package mcsf_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned UNITS_W = 10;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned IDX_W   = 2;

  // one high-word unit: 2^32 us in ms, rounded down
  localparam logic [31:0] UNIT_STEP_MS = 32'd4294967;
  localparam logic [31:0] UNIT_HALF    = UNIT_STEP_MS >> 1;
  // ceil(2^54 / unit): quotient of a value below 2^31 + unit/2 is bits 63:54
  localparam logic [31:0] UNIT_RECIP =
    32'(((64'd1 << 54) + 64'(UNIT_STEP_MS) - 64'd1) / 64'(UNIT_STEP_MS));
  // ceil(2^52 / 1000): floor(n * 2^32 / 1000) is bits 52:20 of n times this
  localparam logic [42:0] EXACT_RECIP = 43'(((64'd1 << 52) + 64'd999) / 64'd1000);

  // register indexes
  localparam logic [IDX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_UNITS = 2'd1;
  localparam logic [IDX_W-1:0] REG_REBASE    = 2'd2;
  localparam logic [IDX_W-1:0] REG_JUMP_THR  = 2'd3;

  typedef enum logic [2:0] {
    EV_FIRST    = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_JUMP     = 3'd2,
    EV_WORDSTEP = 3'd3,
    EV_BACKWARD = 3'd4,
    EV_REBASE   = 3'd5
  } event_kind_t;

  // distance of one sample from one candidate held time
  typedef struct packed {
    logic [31:0]        delta;
    logic               backward;
    logic [31:0]        mag;
    logic [UNITS_W-1:0] units;
  } span_t;

endpackage

`default_nettype wire

// ===== hw/rtl/monotonic_clock_sample_filter_core.sv =====
// monotonic clock sample filter, top level
// depends on mcsf_pkg, mcsf_span, mcsf_fault, monotonic_clock_sample_filter_core_defines.svh
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_stall  | sample_ms
//   out_    | out       | out_valid/out_stall| filtered time, event kind, counters
//   cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// one request per cycle sustained while out_stall stays low; a taken request moves through the
// input register, span stage and output register; the held-time loop closes in the last stage
// reset is synchronous and active low: pipeline empty, counters cleared, registers at defaults
// out_stall propagates back to in_stall within the same cycle through the three stages
`default_nettype none

`include "monotonic_clock_sample_filter_core_defines.svh"

module monotonic_clock_sample_filter_core
  import mcsf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_sample_ms,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_filtered_ms,
  output logic [2:0]              out_event_kind,
  output logic [31:0]             out_backward_count,
  output logic [31:0]             out_word_step_count,
  output logic [UNITS_W-1:0]      out_last_units,
  output logic [31:0]             out_rebase_count,
  output logic signed [31:0]      out_last_rebase_delta,
  output logic [31:0]             out_jump_count,
  output logic [31:0]             out_last_jump_ms,

  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // configuration registers
  logic [TOL_W-1:0]   tol_r;
  logic [UNITS_W-1:0] max_units_r;
  logic [RUN_W-1:0]   rebase_after_r;
  logic [31:0]        jump_thr_r;

  // filter state
  logic               started_r,  started_nxt;
  logic [31:0]        held_r,     held_nxt;
  logic [RUN_W-1:0]   run_r,      run_nxt;
  logic [31:0]        bwd_r,      bwd_nxt;
  logic [31:0]        wst_r,      wst_nxt;
  logic [UNITS_W-1:0] units_r,    units_nxt;
  logic [31:0]        reb_r,      reb_nxt;
  logic [31:0]        rdelta_r,   rdelta_nxt;
  logic [31:0]        jmp_r,      jmp_nxt;
  logic [31:0]        rjump_r,    rjump_nxt;

  // pipeline: input register, span stage, output register
  logic               v0_r, v1_r, vo_r;
  logic [31:0]        s0_r, s1_r;
  span_t              c0_r, c1_r;          // spans against the two held-time candidates
  logic [31:0]        h0_r, h1_r;          // the candidates themselves
  logic [31:0]        filt_r, filt_nxt;
  event_kind_t        kind_r, kind_nxt;

  logic               out_free, mv1, r1_free, mv0, acc_in;
  span_t              c0, c1, cs;
  logic               fault;
  logic               reject;
  logic [RUN_W-1:0]   run_inc;

  // flow control: each stage moves when the one after it is empty or moving
  assign out_free = !vo_r || !out_stall;
  assign mv1      = v1_r && out_free;
  assign r1_free  = !v1_r || mv1;
  assign mv0      = v0_r && r1_free;
  assign in_stall = v0_r && !mv0;
  assign acc_in   = in_valid && !in_stall;

  // when a request enters the span stage, the held time it will see is either the
  // current held time or the sample of the request leaving the span stage now
  mcsf_span u_span_held (
    .sample (s0_r),
    .held   (held_r),
    .span   (c0)
  );

  mcsf_span u_span_prev (
    .sample (s0_r),
    .held   (s1_r),
    .span   (c1)
  );

  // pick the candidate that matches the held time left by the previous request
  assign cs = (held_r != h0_r) ? c1_r : c0_r;

  mcsf_fault u_fault (
    .units     (cs.units),
    .mag       (cs.mag),
    .tolerance (tol_r),
    .max_units (max_units_r),
    .fault     (fault)
  );

  assign run_inc = run_r + 1'b1;

  // decision and state update for the request in the span stage
  always_comb begin
    started_nxt = started_r;
    held_nxt    = held_r;
    run_nxt     = run_r;
    bwd_nxt     = bwd_r;
    wst_nxt     = wst_r;
    units_nxt   = units_r;
    reb_nxt     = reb_r;
    rdelta_nxt  = rdelta_r;
    jmp_nxt     = jmp_r;
    rjump_nxt   = rjump_r;
    filt_nxt    = s1_r;
    kind_nxt    = EV_ACCEPT;
    reject      = 1'b0;

    if (!started_r) begin
      // first reading passes as is
      started_nxt = 1'b1;
      held_nxt    = s1_r;
      kind_nxt    = EV_FIRST;
    end else begin
      // a high-word fault wins over a plain backward step
      if (fault) begin
        wst_nxt   = wst_r + 1'b1;
        units_nxt = cs.units;
        reject    = 1'b1;
        kind_nxt  = EV_WORDSTEP;
      end else if (cs.backward) begin
        bwd_nxt   = bwd_r + 1'b1;
        reject    = 1'b1;
        kind_nxt  = EV_BACKWARD;
      end

      if (reject) begin
        run_nxt = run_inc;
        if (run_inc < rebase_after_r) begin
          filt_nxt = held_r;
        end else begin
          // enough rejects in a row: adopt the new reading
          reb_nxt    = reb_r + 1'b1;
          rdelta_nxt = cs.delta;
          run_nxt    = '0;
          held_nxt   = s1_r;
          kind_nxt   = EV_REBASE;
        end
      end else begin
        run_nxt  = '0;
        held_nxt = s1_r;
        if (cs.mag > jump_thr_r) begin
          jmp_nxt   = jmp_r + 1'b1;
          rjump_nxt = cs.mag;
          kind_nxt  = EV_JUMP;
        end
      end
    end
  end

  // control state, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r           <= 1'b0;
      v1_r           <= 1'b0;
      vo_r           <= 1'b0;
      tol_r          <= 16'd50;
      max_units_r    <= 10'd512;
      rebase_after_r <= 8'd3;
      jump_thr_r     <= 32'd1000;
      started_r      <= 1'b0;
      held_r         <= '0;
      run_r          <= '0;
      bwd_r          <= '0;
      wst_r          <= '0;
      units_r        <= '0;
      reb_r          <= '0;
      rdelta_r       <= '0;
      jmp_r          <= '0;
      rjump_r        <= '0;
    end else begin
      if (acc_in) begin
        v0_r <= 1'b1;
      end else if (mv0) begin
        v0_r <= 1'b0;
      end

      if (mv0) begin
        v1_r <= 1'b1;
      end else if (mv1) begin
        v1_r <= 1'b0;
      end

      if (mv1) begin
        vo_r <= 1'b1;
      end else if (out_free) begin
        vo_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_TOLERANCE: tol_r          <= cfg_data[TOL_W-1:0];
          REG_MAX_UNITS: max_units_r    <= cfg_data[UNITS_W-1:0];
          REG_REBASE:    rebase_after_r <= cfg_data[RUN_W-1:0];
          REG_JUMP_THR:  jump_thr_r     <= cfg_data;
          default: ;
        endcase
      end

      if (mv1) begin
        started_r <= started_nxt;
        held_r    <= held_nxt;
        run_r     <= run_nxt;
        bwd_r     <= bwd_nxt;
        wst_r     <= wst_nxt;
        units_r   <= units_nxt;
        reb_r     <= reb_nxt;
        rdelta_r  <= rdelta_nxt;
        jmp_r     <= jmp_nxt;
        rjump_r   <= rjump_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      s0_r <= in_sample_ms;
    end
    if (mv0) begin
      s1_r <= s0_r;
      c0_r <= c0;
      c1_r <= c1;
      h0_r <= held_r;
      h1_r <= s1_r;
    end
    if (mv1) begin
      filt_r <= filt_nxt;
      kind_r <= kind_nxt;
    end
  end

  // counters only move when a new result is loaded, so they can feed the port directly
  assign out_valid             = vo_r;
  assign out_filtered_ms       = filt_r;
  assign out_event_kind        = kind_r;
  assign out_backward_count    = bwd_r;
  assign out_word_step_count   = wst_r;
  assign out_last_units        = units_r;
  assign out_rebase_count      = reb_r;
  assign out_last_rebase_delta = rdelta_r;
  assign out_jump_count        = jmp_r;
  assign out_last_jump_ms      = rjump_r;

  // the held time always equals the time handed out with the pending result
  `MCSF_CHK_NOW(a_out_is_held, vo_r, filt_r == held_r, "held time differs from result")
  // the held time seen by the span stage is one of its two candidates
  `MCSF_CHK_NOW(a_cand_cover, v1_r && (held_r != h0_r), held_r == h1_r, "no span candidate")
  // any taken or rebased reading ends the reject run
  `MCSF_CHK_NOW(a_run_clear,
    vo_r && (kind_r == EV_FIRST || kind_r == EV_ACCEPT || kind_r == EV_JUMP ||
    kind_r == EV_REBASE), run_r == '0, "reject run not cleared")
  // only the very first reading is reported as first
  `MCSF_CHK_NEXT(a_first_once, mv1 && started_r, kind_r != EV_FIRST, "repeated first event")

endmodule

`default_nettype wire

// ===== hw/rtl/mcsf_span.sv =====
// wrapped distance of a sample from a held time and its rounded unit count
// depends on mcsf_pkg
`default_nettype none

module mcsf_span
  import mcsf_pkg::*;
(
  input  wire logic [31:0] sample,
  input  wire logic [31:0] held,
  output span_t            span
);

  logic [31:0] delta;
  logic [31:0] mag;
  logic [31:0] mag_rnd;
  logic [63:0] prod;

  assign delta   = sample - held;
  assign mag     = delta[31] ? (held - sample) : delta;
  assign mag_rnd = mag + UNIT_HALF;
  // rounded quotient by the unit, via reciprocal
  assign prod    = {32'd0, mag_rnd} * {32'd0, UNIT_RECIP};

  assign span.delta    = delta;
  assign span.backward = delta[31];
  assign span.mag      = mag;
  assign span.units    = prod[63:54];

endmodule

`default_nettype wire

// ===== hw/rtl/mcsf_fault.sv =====
// high-word fault test: distance close to floor(n * 2^32 / 1000)
// depends on mcsf_pkg
`default_nettype none

module mcsf_fault
  import mcsf_pkg::*;
(
  input  wire logic [UNITS_W-1:0] units,
  input  wire logic [31:0]        mag,
  input  wire logic [TOL_W-1:0]   tolerance,
  input  wire logic [UNITS_W-1:0] max_units,
  output logic                    fault
);

  logic [52:0] prod;
  logic [32:0] exact;
  logic [32:0] mag_x;
  logic [32:0] diff;

  assign prod  = {43'd0, units} * {10'd0, EXACT_RECIP};
  assign exact = prod[52:20];
  assign mag_x = {1'b0, mag};
  assign diff  = (mag_x >= exact) ? (mag_x - exact) : (exact - mag_x);

  assign fault = (units != '0) && (units <= max_units) && (diff <= {17'd0, tolerance});

endmodule

`default_nettype wire

// ===== test/mcsf_filter_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the monotonic clock sample filter: predicts each result and compares it
// depends on mcsf_pkg; watches the in_, out_ and cfg_ ports of the core

module mcsf_filter_checker
  import mcsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [31:0]              in_sample_ms,

  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [31:0]              out_filtered_ms,
  input  logic [2:0]               out_event_kind,
  input  logic [31:0]              out_backward_count,
  input  logic [31:0]              out_word_step_count,
  input  logic [UNITS_W-1:0]       out_last_units,
  input  logic [31:0]              out_rebase_count,
  input  logic signed [31:0]       out_last_rebase_delta,
  input  logic [31:0]              out_jump_count,
  input  logic [31:0]              out_last_jump_ms,

  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [31:0]              cfg_data,

  output int unsigned              mismatches,
  output int unsigned              results_due
);

  typedef struct packed {
    logic [31:0]        filtered_ms;
    event_kind_t        event_kind;
    logic [31:0]        backward_count;
    logic [31:0]        word_step_count;
    logic [UNITS_W-1:0] last_units;
    logic [31:0]        rebase_count;
    logic signed [31:0] last_rebase_delta;
    logic [31:0]        jump_count;
    logic [31:0]        last_jump_ms;
  } filter_result_t;

  // register copies
  logic [TOL_W-1:0]   tolerance_ms;
  logic [UNITS_W-1:0] max_units;
  logic [RUN_W-1:0]   rebase_limit;
  logic [31:0]        jump_limit_ms;

  // filter state
  logic               clock_started;
  logic [31:0]        held_ms;
  logic [RUN_W-1:0]   reject_streak;
  logic [31:0]        backward_seen;
  logic [31:0]        word_steps_seen;
  logic [UNITS_W-1:0] latest_units;
  logic [31:0]        rebases_seen;
  logic [31:0]        latest_rebase_delta;
  logic [31:0]        jumps_seen;
  logic [31:0]        latest_jump_ms;

  filter_result_t expected_results[$];

  // unit count when the distance sits within tolerance of a whole high-word unit, else zero
  function automatic logic [UNITS_W-1:0] word_step_units(input logic [31:0] mag);
    logic [63:0] distance, slop, unit, n, whole, gap;
    distance = 64'(mag);
    slop = 64'(tolerance_ms);
    unit = 64'(UNIT_STEP_MS);
    if (distance + slop < unit) return '0;
    n = (distance + unit / 2) / unit;
    if (n == 0 || n > 64'(max_units)) return '0;
    whole = (n << 32) / 64'd1000;
    gap = (distance > whole) ? distance - whole : whole - distance;
    return (gap <= slop) ? n[UNITS_W-1:0] : '0;
  endfunction

  function automatic filter_result_t filter_sample(input logic [31:0] sample);
    filter_result_t r;
    logic [31:0] delta, mag;
    logic backward, rejected;
    logic [UNITS_W-1:0] units;
    event_kind_t kind;
    if (!clock_started) begin
      clock_started = 1'b1;
      held_ms = sample;
      kind = EV_FIRST;
    end else begin
      delta = sample - held_ms;
      backward = delta[31];
      mag = backward ? held_ms - sample : delta;
      units = word_step_units(mag);
      rejected = 1'b1;
      // a word-step fault takes precedence over a backward reading
      if (units != '0) begin
        word_steps_seen++;
        latest_units = units;
        kind = EV_WORDSTEP;
      end else if (backward) begin
        backward_seen++;
        kind = EV_BACKWARD;
      end else begin
        rejected = 1'b0;
        kind = EV_ACCEPT;
      end
      if (rejected) begin
        reject_streak = reject_streak + 1'b1;
        if (reject_streak >= rebase_limit) begin
          rebases_seen++;
          latest_rebase_delta = delta;
          reject_streak = '0;
          held_ms = sample;
          kind = EV_REBASE;
        end
      end else begin
        reject_streak = '0;
        if (mag > jump_limit_ms) begin
          jumps_seen++;
          latest_jump_ms = mag;
          kind = EV_JUMP;
        end
        held_ms = sample;
      end
    end
    r.filtered_ms       = held_ms;
    r.event_kind        = kind;
    r.backward_count    = backward_seen;
    r.word_step_count   = word_steps_seen;
    r.last_units        = latest_units;
    r.rebase_count      = rebases_seen;
    r.last_rebase_delta = latest_rebase_delta;
    r.jump_count        = jumps_seen;
    r.last_jump_ms      = latest_jump_ms;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    filter_result_t due;
    if (!rst_n) begin
      tolerance_ms        = 16'd50;
      max_units           = 10'd512;
      rebase_limit        = 8'd3;
      jump_limit_ms       = 32'd1000;
      clock_started       = 1'b0;
      held_ms             = '0;
      reject_streak       = '0;
      backward_seen       = '0;
      word_steps_seen     = '0;
      latest_units        = '0;
      rebases_seen        = '0;
      latest_rebase_delta = '0;
      jumps_seen          = '0;
      latest_jump_ms      = '0;
      mismatches          = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOLERANCE: tolerance_ms  = cfg_data[TOL_W-1:0];
          REG_MAX_UNITS: max_units     = cfg_data[UNITS_W-1:0];
          REG_REBASE:    rebase_limit  = cfg_data[RUN_W-1:0];
          REG_JUMP_THR:  jump_limit_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result with no request pending: filtered_ms %0h", out_filtered_ms);
        end else begin
          due = expected_results.pop_front();
          check_field("filtered_ms", due.filtered_ms, out_filtered_ms);
          check_field("event_kind", 32'(due.event_kind), 32'(out_event_kind));
          check_field("backward_count", due.backward_count, out_backward_count);
          check_field("word_step_count", due.word_step_count, out_word_step_count);
          check_field("last_units", 32'(due.last_units), 32'(out_last_units));
          check_field("rebase_count", due.rebase_count, out_rebase_count);
          check_field("last_rebase_delta", due.last_rebase_delta, out_last_rebase_delta);
          check_field("jump_count", due.jump_count, out_jump_count);
          check_field("last_jump_ms", due.last_jump_ms, out_last_jump_ms);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(filter_sample(in_sample_ms));
    end
    results_due = expected_results.size();
  end

endmodule

// ===== test/tb_monotonic_clock_sample_filter_core.sv =====
`timescale 1ns / 1ps
// top of the monotonic clock sample filter bench: clock, reset, stimulus and verdict
// depends on mcsf_pkg, monotonic_clock_sample_filter_core and mcsf_filter_checker

module tb_monotonic_clock_sample_filter_core;
  import mcsf_pkg::*;

  // cycles without any accepted request, result or register write before giving up
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 150;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [31:0]         in_sample_ms;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [31:0]         out_filtered_ms;
  logic [2:0]          out_event_kind;
  logic [31:0]         out_backward_count;
  logic [31:0]         out_word_step_count;
  logic [UNITS_W-1:0]  out_last_units;
  logic [31:0]         out_rebase_count;
  logic signed [31:0]  out_last_rebase_delta;
  logic [31:0]         out_jump_count;
  logic [31:0]         out_last_jump_ms;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [31:0]         cfg_data;

  int unsigned         mismatches;
  int unsigned         results_due;

  // stimulus-side view of the registers, used only to aim the samples
  logic [TOL_W-1:0]    tol_now;
  logic [UNITS_W-1:0]  max_units_now;
  logic [RUN_W-1:0]    rebase_now;

  // rough tracking of the held time so that faults and backward steps land near it
  logic [31:0]         clock_base;
  logic [RUN_W-1:0]    misses_in_row;
  int unsigned         burst_left;

  // receiver stall pattern state
  int unsigned         stall_mode = 0;
  int unsigned         stall_left = 0;
  int unsigned         quiet_cycles = 0;

  always #2 clk = ~clk;

  monotonic_clock_sample_filter_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample_ms          (in_sample_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_filtered_ms       (out_filtered_ms),
    .out_event_kind        (out_event_kind),
    .out_backward_count    (out_backward_count),
    .out_word_step_count   (out_word_step_count),
    .out_last_units        (out_last_units),
    .out_rebase_count      (out_rebase_count),
    .out_last_rebase_delta (out_last_rebase_delta),
    .out_jump_count        (out_jump_count),
    .out_last_jump_ms      (out_last_jump_ms),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  mcsf_filter_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample_ms          (in_sample_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_filtered_ms       (out_filtered_ms),
    .out_event_kind        (out_event_kind),
    .out_backward_count    (out_backward_count),
    .out_word_step_count   (out_word_step_count),
    .out_last_units        (out_last_units),
    .out_rebase_count      (out_rebase_count),
    .out_last_rebase_delta (out_last_rebase_delta),
    .out_jump_count        (out_jump_count),
    .out_last_jump_ms      (out_last_jump_ms),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .mismatches            (mismatches),
    .results_due           (results_due)
  );

  // receiver: picks a mode for a random stretch, from never stalling to stalling throughout
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      2:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // watchdog: any accepted request, result or register write counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // whole multiple of the high-word unit: floor(n * 2^32 / 1000)
  function automatic logic [31:0] unit_multiple_ms(input int unsigned n);
    return 32'((64'(n) << 32) / 64'd1000);
  endfunction

  // sender: bursts of requests with random gaps between them; valid stays up inside a burst
  task automatic push_sample(input logic [31:0] sample);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_sample_ms <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // send one sample and follow where the held time probably went
  task automatic note_sample(input logic [31:0] sample, input logic rejected);
    push_sample(sample);
    if (rejected) begin
      misses_in_row = misses_in_row + 1'b1;
      if (misses_in_row >= rebase_now) begin
        clock_base    = sample;
        misses_in_row = '0;
      end
    end else begin
      clock_base    = sample;
      misses_in_row = '0;
    end
  endtask

  // close the current burst and wait for every outstanding result
  task automatic drain();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    while (results_due != 0) @(negedge clk);
  endtask

  // all four registers on consecutive cycles, write enable held high across them
  task automatic write_settings(input logic [TOL_W-1:0] tol, input logic [UNITS_W-1:0] units,
                                input logic [RUN_W-1:0] rebase, input logic [31:0] jump);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOLERANCE;
    cfg_data  <= 32'(tol);
    @(negedge clk);
    cfg_index <= REG_MAX_UNITS;
    cfg_data  <= 32'(units);
    @(negedge clk);
    cfg_index <= REG_REBASE;
    cfg_data  <= 32'(rebase);
    @(negedge clk);
    cfg_index <= REG_JUMP_THR;
    cfg_data  <= jump;
    @(negedge clk);
    cfg_we        <= 1'b0;
    tol_now       = tol;
    max_units_now = units;
    rebase_now    = rebase;
  endtask

  // mostly plausible clock behavior: small forward steps, word-step faults near the held time,
  // short backward steps; the rest is big forward leaps and unrelated readings
  task automatic random_sample();
    int unsigned pick, n, off;
    logic [31:0] span, sample, diff;
    logic back;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      note_sample(clock_base + $urandom_range(0, 3000), 1'b0);
    end else if (pick < 68) begin
      n    = $urandom_range(1, 500);
      off  = $urandom_range(0, 32'(tol_now) + 3);
      span = $urandom_range(0, 1) ? unit_multiple_ms(n) + off : unit_multiple_ms(n) - off;
      back = 1'($urandom_range(0, 1));
      sample = back ? clock_base - span : clock_base + span;
      note_sample(sample, back || (off <= tol_now && n <= max_units_now));
    end else if (pick < 82) begin
      note_sample(clock_base - $urandom_range(1, 5000), 1'b1);
    end else if (pick < 90) begin
      note_sample(clock_base + $urandom_range(0, 32'h7FFF_FFFF), 1'b0);
    end else begin
      sample = $urandom;
      diff   = sample - clock_base;
      note_sample(sample, diff[31]);
    end
  endtask

  initial begin : stimulus
    logic [TOL_W-1:0]   tol;
    logic [UNITS_W-1:0] units;
    logic [RUN_W-1:0]   rebase;
    logic [31:0]        jump;
    in_valid      = 1'b0;
    in_sample_ms  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_TOLERANCE;
    cfg_data      = '0;
    rst_n         = 1'b0;
    tol_now       = 16'd50;
    max_units_now = 10'd512;
    rebase_now    = 8'd3;
    clock_base    = '0;
    misses_in_row = '0;
    burst_left    = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset register values
    note_sample(32'hFFFF_FFF0, 1'b0);                        // first reading near the top
    note_sample(clock_base + 32'd5, 1'b0);
    note_sample(clock_base + 32'd27, 1'b0);                  // wraps through zero
    note_sample(clock_base, 1'b0);                           // no movement at all
    note_sample(clock_base + 32'd2000, 1'b0);                // jump above threshold
    note_sample(clock_base + unit_multiple_ms(1), 1'b1);      // word-step fault, forward
    note_sample(clock_base - unit_multiple_ms(1), 1'b1);      // fault that is also backward
    note_sample(clock_base + unit_multiple_ms(1) + 32'd50, 1'b1); // tolerance edge, rebases
    note_sample(clock_base + unit_multiple_ms(1) + 32'd51, 1'b0); // just outside tolerance
    note_sample(clock_base - 32'd1, 1'b1);                   // backward by one
    note_sample(clock_base - 32'd2, 1'b1);
    note_sample(clock_base ^ 32'h8000_0000, 1'b1);           // half-range distance, 500 units
    note_sample(clock_base - unit_multiple_ms(499) - 32'd50, 1'b1);
    note_sample(clock_base + 32'd3, 1'b0);
    note_sample(32'h0000_0000, 1'b1);
    note_sample(32'hFFFF_FFFF, 1'b1);
    note_sample(clock_base + 32'd1001, 1'b0);                // one above threshold
    note_sample(clock_base + 32'd1000, 1'b0);                // at threshold, no jump

    // random phases; the first two pin every register at its extremes
    for (int unsigned p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          tol = '0; units = '0; rebase = '0; jump = '0;
        end
        1: begin
          tol = '1; units = '1; rebase = '1; jump = '1;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       tol = '0;
            1:       tol = '1;
            2:       tol = TOL_W'($urandom_range(1, 200));
            default: tol = TOL_W'($urandom);
          endcase
          case ($urandom_range(0, 4))
            0:       units = '0;
            1:       units = 10'd1;
            2:       units = 10'd512;
            3:       units = '1;
            default: units = UNITS_W'($urandom_range(1, 512));
          endcase
          case ($urandom_range(0, 3))
            0:       rebase = '0;
            1:       rebase = 8'd1;
            2:       rebase = '1;
            default: rebase = RUN_W'($urandom_range(2, 6));
          endcase
          case ($urandom_range(0, 3))
            0:       jump = '0;
            1:       jump = '1;
            2:       jump = $urandom_range(0, 5000);
            default: jump = $urandom;
          endcase
        end
      endcase
      write_settings(tol, units, rebase, jump);
      repeat (PHASE_ITEMS) random_sample();
    end

    // let the last results out and watch for anything unexpected before the verdict
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
